// ===== rtl/core/irps_pkg.sv =====
// shared types, constants and request table for the register poll sequencer
// no dependencies; used by irps_lane, irps_seq and the top level
package irps_pkg;

  // decoder lanes: one per little-endian 16-bit word of the read data
  localparam int NUM_LANES = 4;
  localparam int WORD_W    = 16;
  localparam int BYTES_W   = NUM_LANES * WORD_W;

  // field widths
  localparam int REG_W      = 8;
  localparam int RLEN_W     = 4;
  localparam int WAIT_W     = 16;
  localparam int BUS_ADDR_W = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS_ADDRESS     = 1'b0,
    CFG_SAMPLE_INTERVAL = 1'b1
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [WAIT_W-1:0] SAMPLE_INTERVAL_RST = 16'd50;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_ID         = 4'd0,
    PH_WR_OPR_CFG = 4'd1,
    PH_WR_PAGE    = 4'd2,
    PH_WR_SYS_TRG = 4'd3,
    PH_WR_OPR_FUS = 4'd4,
    PH_ANGLES     = 4'd5,
    PH_QUAT       = 4'd6,
    PH_LIN_ACC    = 4'd7,
    PH_GRAVITY    = 4'd8,
    PH_TEMP       = 4'd9,
    PH_CALIB      = 4'd10
  } phase_t;

  // kind of decoded sample in a result
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ANGLES  = 3'd1,
    KIND_QUAT    = 3'd2,
    KIND_LIN_ACC = 3'd3,
    KIND_GRAVITY = 3'd4,
    KIND_TEMP    = 3'd5,
    KIND_CALIB   = 3'd6
  } kind_t;

  // what a decoder lane does with its word
  typedef enum logic [1:0] {
    LM_ZERO = 2'd0,
    LM_WORD = 2'd1,
    LM_BYTE = 2'd2
  } lane_mode_t;

  // sensor register addresses
  localparam logic [REG_W-1:0] REG_CHIP_ID   = 8'h00;
  localparam logic [REG_W-1:0] REG_OPR_MODE  = 8'h3D;
  localparam logic [REG_W-1:0] REG_PAGE_ID   = 8'h07;
  localparam logic [REG_W-1:0] REG_SYS_TRG   = 8'h3F;
  localparam logic [REG_W-1:0] REG_EULER     = 8'h1A;
  localparam logic [REG_W-1:0] REG_QUAT      = 8'h20;
  localparam logic [REG_W-1:0] REG_LIN_ACC   = 8'h28;
  localparam logic [REG_W-1:0] REG_GRAVITY   = 8'h2E;
  localparam logic [REG_W-1:0] REG_TEMP      = 8'h34;
  localparam logic [REG_W-1:0] REG_CALIB     = 8'h35;

  // values written during set-up
  localparam logic [7:0] VAL_MODE_CONFIG = 8'h00;
  localparam logic [7:0] VAL_PAGE_ZERO   = 8'h00;
  localparam logic [7:0] VAL_EXT_CLOCK   = 8'h80;
  localparam logic [7:0] VAL_MODE_FUSION = 8'h0C;
  localparam logic [7:0] CALIB_ALL_DONE  = 8'hFF;

  // waits in ms after a successful transfer
  localparam logic [WAIT_W-1:0] WAIT_AFTER_ID     = 16'd1000;
  localparam logic [WAIT_W-1:0] WAIT_AFTER_CFG    = 16'd25;
  localparam logic [WAIT_W-1:0] WAIT_AFTER_PAGE   = 16'd10;
  localparam logic [WAIT_W-1:0] WAIT_AFTER_SYS    = 16'd10;
  localparam logic [WAIT_W-1:0] WAIT_AFTER_FUSION = 16'd600;

  // one bus request
  typedef struct packed {
    logic [REG_W-1:0]  register;
    logic              is_write;
    logic [7:0]        write_value;
    logic [RLEN_W-1:0] read_length;
  } req_t;

  // sequencer result handed to the output stage
  typedef struct packed {
    req_t              req;
    logic [WAIT_W-1:0] wait_ms;
    kind_t             kind;
    logic              calibrated;
  } seq_res_t;

  // request table per phase
  function automatic req_t req_for(input phase_t ph);
    req_t r;
    r = '{register: REG_CHIP_ID, is_write: 1'b0, write_value: 8'h00, read_length: 4'd1};
    unique case (ph)
      PH_ID:         r = '{REG_CHIP_ID, 1'b0, 8'h00, 4'd1};
      PH_WR_OPR_CFG: r = '{REG_OPR_MODE, 1'b1, VAL_MODE_CONFIG, 4'd0};
      PH_WR_PAGE:    r = '{REG_PAGE_ID, 1'b1, VAL_PAGE_ZERO, 4'd0};
      PH_WR_SYS_TRG: r = '{REG_SYS_TRG, 1'b1, VAL_EXT_CLOCK, 4'd0};
      PH_WR_OPR_FUS: r = '{REG_OPR_MODE, 1'b1, VAL_MODE_FUSION, 4'd0};
      PH_ANGLES:     r = '{REG_EULER, 1'b0, 8'h00, 4'd6};
      PH_QUAT:       r = '{REG_QUAT, 1'b0, 8'h00, 4'd8};
      PH_LIN_ACC:    r = '{REG_LIN_ACC, 1'b0, 8'h00, 4'd6};
      PH_GRAVITY:    r = '{REG_GRAVITY, 1'b0, 8'h00, 4'd6};
      PH_TEMP:       r = '{REG_TEMP, 1'b0, 8'h00, 4'd1};
      PH_CALIB:      r = '{REG_CALIB, 1'b0, 8'h00, 4'd1};
      default:       r = '{REG_CHIP_ID, 1'b0, 8'h00, 4'd1};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/imu_register_poll_sequencer.sv =====
// top level of the register poll sequencer: configuration, decoder lanes,
// sequencer and output register; depends on irps_pkg, irps_lane, irps_seq

// Each request reports the outcome of one bus transfer and returns exactly one
// result naming the next transfer, its wait and any decoded sample. A request
// is taken every clock cycle unless a stalled output holds an unread result,
// and its result appears in the output register in the next cycle. A new
// request is taken in the same cycle that the previous result leaves, so the
// input is stalled only while an unread result is held by a stalled output.
// Four decoder lanes split the read data into little-endian 16-bit words in
// parallel; samples are raw two's complement counts. Writes to the bus
// address register index are accepted but ignored by this block.
module imu_register_poll_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [irps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // transfer outcome
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_transfer_ok,
  input  logic [irps_pkg::BYTES_W-1:0]        in_read_bytes,
  // next request and decoded sample
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [irps_pkg::REG_W-1:0]          out_next_register,
  output logic                                out_next_is_write,
  output logic [7:0]                          out_next_write_value,
  output logic [irps_pkg::RLEN_W-1:0]         out_next_read_length,
  output logic [irps_pkg::WAIT_W-1:0]         out_wait_ms,
  output logic [2:0]                          out_sample_kind,
  output logic signed [irps_pkg::WORD_W-1:0]  out_sample_a,
  output logic signed [irps_pkg::WORD_W-1:0]  out_sample_b,
  output logic signed [irps_pkg::WORD_W-1:0]  out_sample_c,
  output logic signed [irps_pkg::WORD_W-1:0]  out_sample_d,
  output logic                                out_calibrated
);

  logic [irps_pkg::WAIT_W-1:0]         interval_r;
  logic                                in_acc;
  logic                                out_valid_r, out_valid_nxt;
  irps_pkg::seq_res_t                  res;
  irps_pkg::seq_res_t                  res_r;
  irps_pkg::lane_mode_t [irps_pkg::NUM_LANES-1:0] lane_mode;
  logic signed [irps_pkg::WORD_W-1:0]  lane_sample [irps_pkg::NUM_LANES];
  logic signed [irps_pkg::WORD_W-1:0]  sample_r    [irps_pkg::NUM_LANES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= irps_pkg::SAMPLE_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (irps_pkg::cfg_reg_t'(cfg_index))
        irps_pkg::CFG_SAMPLE_INTERVAL: interval_r <= cfg_wdata;
        irps_pkg::CFG_BUS_ADDRESS:     interval_r <= interval_r;
        default:                       interval_r <= interval_r;
      endcase
    end
  end

  // handshake: take a request whenever the output register is free or draining
  assign in_stall      = out_valid_r & out_stall;
  assign in_acc        = in_valid & ~in_stall;
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  // phase sequencer
  irps_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_acc),
    .ok              (in_transfer_ok),
    .bytes           (in_read_bytes),
    .sample_interval (interval_r),
    .res             (res),
    .lane_mode       (lane_mode)
  );

  // word decoder lanes
  for (genvar i = 0; i < irps_pkg::NUM_LANES; i++) begin : g_lane
    irps_lane u_lane (
      .word   (in_read_bytes[irps_pkg::WORD_W*i +: irps_pkg::WORD_W]),
      .mode   (lane_mode[i]),
      .sample (lane_sample[i])
    );
  end

  // output register: merges sequencer result and lane samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r    <= res;
      sample_r <= lane_sample;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_next_register    = res_r.req.register;
  assign out_next_is_write    = res_r.req.is_write;
  assign out_next_write_value = res_r.req.write_value;
  assign out_next_read_length = res_r.req.read_length;
  assign out_wait_ms          = res_r.wait_ms;
  assign out_sample_kind      = res_r.kind;
  assign out_calibrated       = res_r.calibrated;
  assign out_sample_a         = sample_r[0];
  assign out_sample_b         = sample_r[1];
  assign out_sample_c         = sample_r[2];
  assign out_sample_d         = sample_r[3];

  // every accepted request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted request produced no result");

  // a failed transfer reports no sample
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_transfer_ok |=> out_sample_kind == irps_pkg::KIND_NONE &&
      out_sample_a == 0 && out_sample_b == 0 && out_sample_c == 0 && out_sample_d == 0)
    else $error("failed transfer reported a sample");

  // a write request never asks for read bytes
  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_is_write |-> out_next_read_length == 0)
    else $error("write request carries a read length");

endmodule

// ===== rtl/core/irps_lane.sv =====
// one decoder lane: turns a little-endian word of read data into a signed count
// depends on irps_pkg
module irps_lane (
  input  logic [irps_pkg::WORD_W-1:0]        word,
  input  irps_pkg::lane_mode_t               mode,
  output logic signed [irps_pkg::WORD_W-1:0] sample
);

  // zero, whole word, or sign-extended low byte
  always_comb begin
    case (mode)
      irps_pkg::LM_WORD: sample = word;
      irps_pkg::LM_BYTE: sample = {{(irps_pkg::WORD_W-8){word[7]}}, word[7:0]};
      default:           sample = '0;
    endcase
  end

endmodule

// ===== rtl/core/irps_seq.sv =====
// phase sequencer: holds phase, wait and calibrated flag, picks the next request
// and tells each decoder lane what to do; depends on irps_pkg
module irps_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic                                ok,
  input  logic [irps_pkg::BYTES_W-1:0]        bytes,
  input  logic [irps_pkg::WAIT_W-1:0]         sample_interval,
  output irps_pkg::seq_res_t                  res,
  output irps_pkg::lane_mode_t [irps_pkg::NUM_LANES-1:0] lane_mode
);

  irps_pkg::phase_t            phase_r, phase_nxt;
  logic [irps_pkg::WAIT_W-1:0] wait_r, wait_nxt;
  logic                        calib_r, calib_nxt;
  irps_pkg::phase_t            cur;
  irps_pkg::kind_t             kind;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= irps_pkg::PH_ID;
      wait_r  <= '0;
      calib_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      calib_r <= calib_nxt;
    end
  end

  // step rule for one completed request
  always_comb begin
    cur       = (phase_r > irps_pkg::PH_CALIB) ? irps_pkg::PH_ID : phase_r;
    phase_nxt = cur;
    wait_nxt  = wait_r;
    calib_nxt = calib_r;
    kind      = irps_pkg::KIND_NONE;
    lane_mode = '{default: irps_pkg::LM_ZERO};
    if (ok) begin
      unique case (cur) inside
        irps_pkg::PH_ID:         wait_nxt = irps_pkg::WAIT_AFTER_ID;
        irps_pkg::PH_WR_OPR_CFG: wait_nxt = irps_pkg::WAIT_AFTER_CFG;
        irps_pkg::PH_WR_PAGE:    wait_nxt = irps_pkg::WAIT_AFTER_PAGE;
        irps_pkg::PH_WR_SYS_TRG: wait_nxt = irps_pkg::WAIT_AFTER_SYS;
        irps_pkg::PH_WR_OPR_FUS: wait_nxt = irps_pkg::WAIT_AFTER_FUSION;
        irps_pkg::PH_ANGLES, irps_pkg::PH_QUAT,
        irps_pkg::PH_LIN_ACC, irps_pkg::PH_GRAVITY: begin
          kind         = irps_pkg::kind_t'(3'(cur - irps_pkg::PH_WR_OPR_FUS));
          lane_mode[0] = irps_pkg::LM_WORD;
          lane_mode[1] = irps_pkg::LM_WORD;
          lane_mode[2] = irps_pkg::LM_WORD;
          if (cur == irps_pkg::PH_QUAT) lane_mode[3] = irps_pkg::LM_WORD;
          wait_nxt     = sample_interval;
        end
        irps_pkg::PH_TEMP: begin
          kind         = irps_pkg::KIND_TEMP;
          lane_mode[0] = irps_pkg::LM_BYTE;
        end
        irps_pkg::PH_CALIB: begin
          kind      = irps_pkg::KIND_CALIB;
          calib_nxt = (bytes[7:0] == irps_pkg::CALIB_ALL_DONE);
        end
        default: wait_nxt = irps_pkg::WAIT_AFTER_ID;
      endcase
      phase_nxt = (cur == irps_pkg::PH_CALIB) ? irps_pkg::PH_ANGLES
                                              : irps_pkg::phase_t'(4'(cur) + 4'd1);
    end
    res.req        = irps_pkg::req_for(phase_nxt);
    res.wait_ms    = wait_nxt;
    res.kind       = kind;
    res.calibrated = calib_nxt;
  end

  // calibration status wraps back to the angle read
  a_calib_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ok && phase_r == irps_pkg::PH_CALIB |=> phase_r == irps_pkg::PH_ANGLES)
    else $error("calibration phase did not return to angle read");

  // a failed transfer keeps phase and wait
  a_retry_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ok |=> $stable(phase_r) && $stable(wait_r))
    else $error("failed transfer moved the sequencer");

  // calibrated flag moves only on a calibration read
  a_calib_only: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && ok && phase_r == irps_pkg::PH_CALIB) |=> $stable(calib_r))
    else $error("calibrated flag changed outside calibration read");

  // no sample is reported after a failed transfer
  a_fail_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !ok |-> kind == irps_pkg::KIND_NONE && lane_mode == {irps_pkg::NUM_LANES{irps_pkg::LM_ZERO}})
    else $error("sample decoded on failed transfer");

endmodule
